>>> design/assert_macros.svh
// Assertion helper macros shared by the stack RTL.
// Depends on nothing; users must have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/bswr_pkg.sv
// Shared command codes, status codes and control structs for the byte stack.
// No dependencies.
package bswr_pkg;

   localparam logic [2:0] CMD_PUSH     = 3'd0;
   localparam logic [2:0] CMD_POP      = 3'd1;
   localparam logic [2:0] CMD_PEEK     = 3'd2;
   localparam logic [2:0] CMD_DUP      = 3'd3;
   localparam logic [2:0] CMD_ROT_UP   = 3'd4;
   localparam logic [2:0] CMD_ROT_DOWN = 3'd5;
   localparam logic [2:0] CMD_PRINT    = 3'd6;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_BADCNT = 2'd3;

   localparam logic [5:0] CAP_RESET = 6'd32;

   // controller -> datapath
   typedef struct packed {
      logic exec;        // run a single-result request this cycle
      logic print_load;  // clear the print index
      logic print_emit;  // emit entry at print index, advance index
   } bswr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fill_empty;
      logic idx_last;    // print index points at the bottom entry
   } bswr_stat_type;

endpackage

>>> design/bswr_ctrl.sv
// Request sequencer for the byte stack: idle / print streaming.
// Depends on bswr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bswr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             req_cmd,
   input  bswr_pkg::bswr_stat_type stat,
   output bswr_pkg::bswr_cmd_type  cmd,
   output logic                   busy
);
   import bswr_pkg::*;

   typedef enum logic {ST_IDLE, ST_PRINT} state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      cmd.exec       = 1'b0;
      cmd.print_load = 1'b0;
      cmd.print_emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_PRINT && !stat.fill_empty) begin
                  cmd.print_load = 1'b1;
                  state_in       = ST_PRINT;
                  busy_in        = 1'b1;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_PRINT: begin
            cmd.print_emit = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   `CHK_IMPLY(a_busy_matches_print, busy_ff, state_ff == ST_PRINT, "busy out of step with state")
   `CHK_IMPLY(a_no_exec_when_busy, busy_ff, !cmd.exec && !cmd.print_load, "request run while busy")
endmodule

>>> design/bswr_dpath.sv
// Stack cells, fill count, capacity register and response registers.
// Depends on bswr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bswr_dpath #(
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bswr_pkg::bswr_cmd_type  cmd,
   output bswr_pkg::bswr_stat_type stat,
   input  logic [2:0]             req_cmd,
   input  logic [7:0]             req_push_value,
   input  logic [5:0]             req_rotate_count,
   input  logic                   csr_wr_en,
   input  logic [5:0]             csr_wr_data,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_value,
   output logic                   rsp_value_valid,
   output logic                   rsp_last
);
   import bswr_pkg::*;

   localparam int FW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (FW > 6) ? FW : 6;

   // cell 0 is the top of the stack
   logic [DEPTH-1:0][7:0] cells_ff, cells_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [5:0]            cap_ff;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [7:0]            rsp_value_ff, rsp_value_in;
   logic                  rsp_vv_ff, rsp_vv_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CMPW-1:0]       fill_x, cap_x, r_x, cap_eff, rm1;
   logic [IW-1:0]         raddr;
   logic [7:0]            rd;
   logic                  full, empty, bad_cnt, rot_act;
   logic [DEPTH-1:0][7:0] push_vec, dup_vec, pop_vec;

   assign fill_x  = CMPW'(fill_ff);
   assign cap_x   = CMPW'(cap_ff);
   assign r_x     = CMPW'(req_rotate_count);
   assign cap_eff = (cap_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_x;
   assign full    = fill_x >= cap_eff;
   assign empty   = (fill_ff == '0);
   assign bad_cnt = r_x > fill_x;
   assign rot_act = r_x >= CMPW'(2);
   assign rm1     = r_x - CMPW'(1);

   // one shared read port: print index or rotate-down source
   assign raddr = cmd.print_emit ? idx_ff : rm1[IW-1:0];
   assign rd    = cells_ff[raddr];

   assign push_vec = {cells_ff[DEPTH-2:0], req_push_value};
   assign dup_vec  = {cells_ff[DEPTH-2:0], cells_ff[0]};
   assign pop_vec  = {cells_ff[DEPTH-1], cells_ff[DEPTH-1:1]};

   assign stat.fill_empty = empty;
   assign stat.idx_last   = (CMPW'(idx_ff) + CMPW'(1)) == fill_x;

   always_comb begin
      cells_in      = cells_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = 8'd0;
      rsp_vv_in     = 1'b0;
      rsp_last_in   = 1'b1;

      if (cmd.print_load) begin
         idx_in = '0;
      end

      if (cmd.exec) begin
         rsp_strobe_in = 1'b1;
         case (req_cmd)
            CMD_PUSH: begin
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  cells_in = push_vec;
                  fill_in  = fill_ff + FW'(1);
               end
            end
            CMD_POP: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  cells_in = pop_vec;
                  fill_in  = fill_ff - FW'(1);
               end
            end
            CMD_PEEK: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_value_in = cells_ff[0];
                  rsp_vv_in    = 1'b1;
               end
            end
            CMD_DUP: begin
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  cells_in = dup_vec;
                  fill_in  = fill_ff + FW'(1);
               end
            end
            CMD_ROT_UP: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else if (bad_cnt) begin
                  rsp_status_in = STAT_BADCNT;
               end else if (rot_act) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMPW'(i) < rm1) begin
                        cells_in[i] = pop_vec[i];
                     end else if (CMPW'(i) == rm1) begin
                        cells_in[i] = cells_ff[0];
                     end
                  end
               end
            end
            CMD_ROT_DOWN: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else if (bad_cnt) begin
                  rsp_status_in = STAT_BADCNT;
               end else if (rot_act) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (i == 0) begin
                        cells_in[i] = rd;
                     end else if (CMPW'(i) < r_x) begin
                        cells_in[i] = push_vec[i];
                     end
                  end
               end
            end
            default: begin
               // empty print and the unused code: plain ok
            end
         endcase
      end else if (cmd.print_emit) begin
         rsp_strobe_in = 1'b1;
         rsp_value_in  = rd;
         rsp_vv_in     = 1'b1;
         rsp_last_in   = stat.idx_last;
         idx_in        = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         cap_ff        <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff      <= cells_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_vv_ff     <= rsp_vv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_value_valid = rsp_vv_ff;
   assign rsp_last        = rsp_last_ff;

   `CHK_ALWAYS(a_fill_bound, CMPW'(fill_ff) <= CMPW'(DEPTH), "fill beyond depth")
   `CHK_ALWAYS(a_one_action, !(cmd.exec && cmd.print_emit), "exec and print emit together")
   `CHK_IMPLY(a_no_value_unless_valid, rsp_strobe_ff && !rsp_vv_ff, rsp_value_ff == 8'd0, "value without valid")
endmodule

>>> design/byte_stack_with_rotate.sv
// Byte stack top level: sequencer plus cell-chain datapath (bswr_pkg).
// Push/pop/peek/dup/rotate: one response in the cycle after accept; busy stays low,
// so one request per cycle. Print of n>0 entries: busy high while the entries are
// emitted; after the print index is loaded, responses follow on consecutive cycles.
// Reset (synchronous, active high): stack empty, capacity 32, no response pending.
module byte_stack_with_rotate #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   // request channel: accepted when start && !busy
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_push_value,
   input  logic [5:0] req_rotate_count,
   // response channel: one cycle per response, cannot be stalled
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_value,
   output logic       rsp_value_valid,
   output logic       rsp_last,
   // capacity register write
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);
   import bswr_pkg::*;

   bswr_cmd_type  cmd;
   bswr_stat_type stat;

   // The sequencer only steps through print; every other request is
   // finished by the datapath in the cycle it is accepted, the whole cell
   // chain shifting or rotating at once.
   bswr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   // Cells are held top-first; print reads one cell a cycle through the
   // single read mux, which rotate-down also uses for its source cell.
   bswr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_push_value   (req_push_value),
      .req_rotate_count (req_rotate_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_value_valid  (rsp_value_valid),
      .rsp_last         (rsp_last)
   );
endmodule
